FILE: sv/gvfm_pkg.sv
// Package for the greedy voxel face mesher.
// Holds request kinds, register indexes, entry widths and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package gvfm_pkg;

    localparam int VOX_W  = 25;
    localparam int CELL_W = 26;
    localparam int RGB_W  = 24;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 56;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BUILD,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_WID_RD,
        ST_WID_CHK,
        ST_GROW_RD,
        ST_GROW_CHK,
        ST_CLEAR,
        ST_SLICE_END,
        ST_RESP
    } state_t;

endpackage

FILE: sv/gvfm_vox_store.sv
// Voxel store: 2^AW entries of solid bit and colour, two read ports, one write port.
// Sweeps every entry to empty after reset. Depends on gvfm_pkg.
`timescale 1ns / 1ps

module gvfm_vox_store
    import gvfm_pkg::*;
#(
    parameter int AW = 12
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [VOX_W-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [VOX_W-1:0] rd_data_a,
    output logic [VOX_W-1:0] rd_data_b,
    output logic             busy
);

    localparam int DEPTH = 1 << AW;

    logic [VOX_W-1:0] mem [DEPTH];
    logic             clr_busy_reg;
    logic [AW-1:0]    clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

    assign busy = clr_busy_reg;

endmodule

FILE: sv/greedy_voxel_face_mesher.sv
// Greedy voxel face mesher top level: config registers, sequencer, face mask memory.
// Depends on gvfm_pkg and gvfm_vox_store.
//
// channel | dir | handshake              | payload
// s_      | in  | s_tvalid / s_tready    | s_tuser kind, s_tdata voxel write
// m_      | out | m_tvalid / m_tready    | m_tuser done_res, m_tdata quad
// apb     | in  | psel penable pwrite    | paddr, pwdata, prdata (size_x/y/z)
//
// A fetch rebuilds each slice mask it enters (one cell per cycle, two store reads), scans
// the mask cell by cell, widens and grows the quad from the first set cell and clears the
// cells of the quad. After reset the store is swept to empty.
// A finished result waits in the output register; the next request is taken meanwhile.
`timescale 1ns / 1ps

module greedy_voxel_face_mesher
    import gvfm_pkg::*;
#(
    parameter int DIM = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // vox_x, vox_y, vox_z, is_solid, voxel_rgb
    input  logic                   s_tuser,  // kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,  // axis, faces_positive, pos_x, pos_y,
                                             // pos_z, span_u, span_v, quad_rgb
    output logic                   m_tuser,  // done_res
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int CW = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int EW = $clog2(DIM + 1);
    localparam int AW = 3 * CW;
    localparam int MW = 2 * CW;
    localparam int MDEPTH = 1 << MW;

    state_t state_reg, state_next;

    logic [4:0]        size_x_reg, size_y_reg, size_z_reg;
    logic [1:0]        axis_reg, axis_next;
    logic [EW-1:0]     slice_reg, slice_next;
    logic [EW-1:0]     row_reg, row_next, col_reg, col_next;
    logic              mask_ready_reg, mask_ready_next;
    logic              all_done_reg, all_done_next;
    logic [EW-1:0]     bi_reg, bi_next, bj_reg, bj_next;
    logic [EW-1:0]     w_reg, w_next, h_reg, h_next, k_reg, k_next;
    logic [EW-1:0]     cx_reg, cx_next, cy_reg, cy_next;
    logic [CELL_W-1:0] m_reg, m_next;
    logic              res_done_reg, res_done_next;
    logic              p_vld_reg, p_vld_next, p_aok_reg, p_aok_next, p_bok_reg, p_bok_next;
    logic [MW-1:0]     p_idx_reg, p_idx_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic                   m_tuser_reg, m_tuser_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [EW-1:0] ext_x, ext_y, ext_z, ext_u, ext_v, ext_d;
    logic [EW:0]   col_w, row_h;
    logic          in_acc, cfg_wr, out_free;

    logic [CELL_W-1:0] mask_mem [MDEPTH];
    logic [CELL_W-1:0] mask_q;
    logic              mw_en;
    logic [MW-1:0]     mw_addr, mr_addr;
    logic [CELL_W-1:0] mw_data;

    logic             vw_en, st_busy;
    logic [AW-1:0]    vw_addr, vr_addr_a, vr_addr_b;
    logic [VOX_W-1:0] vr_data_a, vr_data_b;

    logic [3:0]  in_x, in_y, in_z;
    logic        sa, sb;
    logic [4:0]  px, py, pz;

    function automatic logic [EW-1:0] clip_ext(input logic [4:0] sz);
        return (32'(sz) > DIM) ? EW'(DIM) : EW'(sz);
    endfunction

    function automatic logic [CW-1:0] cidx(input logic [3:0] c);
        logic [CW+3:0] t;
        t = (CW + 4)'(c);
        return t[CW-1:0];
    endfunction

    function automatic logic [MW-1:0] midx(input logic [EW:0] r, input logic [EW:0] c);
        return {r[CW-1:0], c[CW-1:0]};
    endfunction

    function automatic logic [AW-1:0] vaddr(input logic [1:0] d, input logic [EW-1:0] s,
                                            input logic [EW-1:0] i, input logic [EW-1:0] j);
        logic [CW-1:0] sc, ic, jc;
        sc = s[CW-1:0];
        ic = i[CW-1:0];
        jc = j[CW-1:0];
        unique case (d)
            AXIS_X:  return {jc, ic, sc};
            AXIS_Y:  return {ic, sc, jc};
            default: return {sc, jc, ic};
        endcase
    endfunction

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= 5'd16;
            size_y_reg <= 5'd16;
            size_z_reg <= 5'd16;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_SIZE_X: size_x_reg <= pwdata[4:0];
                REG_SIZE_Y: size_y_reg <= pwdata[4:0];
                REG_SIZE_Z: size_z_reg <= pwdata[4:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SIZE_X: prdata = {27'd0, size_x_reg};
            REG_SIZE_Y: prdata = {27'd0, size_y_reg};
            REG_SIZE_Z: prdata = {27'd0, size_z_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // extents per axis role
    assign ext_x = clip_ext(size_x_reg);
    assign ext_y = clip_ext(size_y_reg);
    assign ext_z = clip_ext(size_z_reg);

    always_comb
    begin
        unique case (axis_reg)
            AXIS_X:
            begin
                ext_u = ext_y; ext_v = ext_z; ext_d = ext_x;
            end
            AXIS_Y:
            begin
                ext_u = ext_z; ext_v = ext_x; ext_d = ext_y;
            end
            default:
            begin
                ext_u = ext_x; ext_v = ext_y; ext_d = ext_z;
            end
        endcase
    end

    assign col_w = {1'b0, col_reg} + {1'b0, w_reg};
    assign row_h = {1'b0, row_reg} + {1'b0, h_reg};

    assign s_tready = (state_reg == ST_IDLE) && !st_busy;
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign in_x = s_tdata[3:0];
    assign in_y = s_tdata[7:4];
    assign in_z = s_tdata[11:8];

    // voxel store
    assign vw_en = in_acc && (s_tuser == KIND_WRITE) && (32'(in_x) < DIM)
                   && (32'(in_y) < DIM) && (32'(in_z) < DIM);
    assign vw_addr   = {cidx(in_z), cidx(in_y), cidx(in_x)};
    assign vr_addr_a = vaddr(axis_reg, slice_reg - EW'(1), bi_reg, bj_reg);
    assign vr_addr_b = vaddr(axis_reg, slice_reg, bi_reg, bj_reg);

    gvfm_vox_store #(
        .AW(AW)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (vw_en),
        .wr_addr   (vw_addr),
        .wr_data   ({s_tdata[12], s_tdata[36:13]}),
        .rd_addr_a (vr_addr_a),
        .rd_addr_b (vr_addr_b),
        .rd_data_a (vr_data_a),
        .rd_data_b (vr_data_b),
        .busy      (st_busy)
    );

    // face mask memory
    assign sa = vr_data_a[VOX_W-1] && p_aok_reg;
    assign sb = vr_data_b[VOX_W-1] && p_bok_reg;

    always_comb
    begin
        mw_en   = 1'b0;
        mw_addr = p_idx_reg;
        mw_data = '0;
        if (p_vld_reg)
        begin
            mw_en = 1'b1;
            if (sa != sb)
            begin
                mw_data = sa ? {2'b11, vr_data_a[RGB_W-1:0]} : {2'b10, vr_data_b[RGB_W-1:0]};
            end
        end
        else if (state_reg == ST_CLEAR)
        begin
            mw_en   = 1'b1;
            mw_addr = midx({1'b0, row_reg} + {1'b0, cy_reg}, {1'b0, col_reg} + {1'b0, cx_reg});
        end
    end

    always_comb
    begin
        unique case (state_reg)
            ST_WID_RD:  mr_addr = midx({1'b0, row_reg}, col_w);
            ST_GROW_RD: mr_addr = midx(row_h, {1'b0, col_reg} + {1'b0, k_reg});
            default:    mr_addr = midx({1'b0, row_reg}, {1'b0, col_reg});
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mw_en)
        begin
            mask_mem[mw_addr] <= mw_data;
        end
        mask_q <= mask_mem[mr_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_tuser == KIND_WRITE || all_done_reg)
                        state_next = ST_RESP;
                    else if (!mask_ready_reg)
                        state_next = ST_BUILD;
                    else
                        state_next = ST_SCAN_RD;
                end
            end
            ST_BUILD:
            begin
                if (!(bj_reg < ext_v && ext_u != '0) && !p_vld_reg)
                    state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                if (row_reg >= ext_v)
                    state_next = ST_SLICE_END;
                else if (col_reg < ext_u)
                    state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                state_next = (mask_q == '0) ? ST_SCAN_RD : ST_WID_RD;
            end
            ST_WID_RD:
            begin
                state_next = (col_w < {1'b0, ext_u}) ? ST_WID_CHK : ST_GROW_RD;
            end
            ST_WID_CHK:
            begin
                state_next = (mask_q == m_reg) ? ST_WID_RD : ST_GROW_RD;
            end
            ST_GROW_RD:
            begin
                if (row_h >= {1'b0, ext_v})
                    state_next = ST_CLEAR;
                else if (k_reg != w_reg)
                    state_next = ST_GROW_CHK;
            end
            ST_GROW_CHK:
            begin
                state_next = (mask_q == m_reg) ? ST_GROW_RD : ST_CLEAR;
            end
            ST_CLEAR:
            begin
                if (cx_reg + EW'(1) == w_reg && cy_reg + EW'(1) == h_reg)
                    state_next = ST_RESP;
            end
            ST_SLICE_END:
            begin
                if (slice_reg == ext_d && axis_reg == AXIS_Z)
                    state_next = ST_RESP;
                else
                    state_next = ST_BUILD;
            end
            ST_RESP:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // register updates per state
    always_comb
    begin
        axis_next       = axis_reg;
        slice_next      = slice_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        mask_ready_next = mask_ready_reg;
        all_done_next   = all_done_reg;
        bi_next         = bi_reg;
        bj_next         = bj_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        k_next          = k_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        m_next          = m_reg;
        res_done_next   = res_done_reg;
        p_vld_next      = 1'b0;
        p_aok_next      = p_aok_reg;
        p_bok_next      = p_bok_reg;
        p_idx_next      = p_idx_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tuser_next    = m_tuser_reg;
        m_tdata_next    = m_tdata_reg;

        if (state_next == ST_BUILD && state_reg != ST_BUILD)
        begin
            bi_next         = '0;
            bj_next         = '0;
            row_next        = '0;
            col_next        = '0;
            mask_ready_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                res_done_next = 1'b1;
                if (in_acc && s_tuser == KIND_FETCH && !all_done_reg)
                    res_done_next = 1'b0;
            end
            ST_BUILD:
            begin
                if (bj_reg < ext_v && ext_u != '0)
                begin
                    p_vld_next = 1'b1;
                    p_aok_next = (slice_reg != '0) && (slice_reg - EW'(1) < ext_d);
                    p_bok_next = slice_reg < ext_d;
                    p_idx_next = midx({1'b0, bj_reg}, {1'b0, bi_reg});
                    if (bi_reg + EW'(1) == ext_u)
                    begin
                        bi_next = '0;
                        bj_next = bj_reg + EW'(1);
                    end
                    else
                    begin
                        bi_next = bi_reg + EW'(1);
                    end
                end
            end
            ST_SCAN_RD:
            begin
                if (row_reg < ext_v && col_reg >= ext_u)
                begin
                    row_next = row_reg + EW'(1);
                    col_next = '0;
                end
            end
            ST_SCAN_CHK:
            begin
                if (mask_q == '0)
                begin
                    col_next = col_reg + EW'(1);
                end
                else
                begin
                    m_next = mask_q;
                    w_next = EW'(1);
                end
            end
            ST_WID_RD:
            begin
                h_next = EW'(1);
                k_next = '0;
            end
            ST_WID_CHK:
            begin
                if (mask_q == m_reg)
                    w_next = w_reg + EW'(1);
            end
            ST_GROW_RD:
            begin
                cx_next = '0;
                cy_next = '0;
                if (row_h < {1'b0, ext_v} && k_reg == w_reg)
                begin
                    h_next = h_reg + EW'(1);
                    k_next = '0;
                end
            end
            ST_GROW_CHK:
            begin
                cx_next = '0;
                cy_next = '0;
                if (mask_q == m_reg)
                    k_next = k_reg + EW'(1);
            end
            ST_CLEAR:
            begin
                if (cx_reg + EW'(1) == w_reg)
                begin
                    cx_next = '0;
                    cy_next = cy_reg + EW'(1);
                end
                else
                begin
                    cx_next = cx_reg + EW'(1);
                end
            end
            ST_SLICE_END:
            begin
                if (slice_reg == ext_d)
                begin
                    slice_next = '0;
                    axis_next  = axis_reg + 2'd1;
                    if (axis_reg == AXIS_Z)
                    begin
                        mask_ready_next = 1'b0;
                        all_done_next   = 1'b1;
                        res_done_next   = 1'b1;
                    end
                end
                else
                begin
                    slice_next = slice_reg + EW'(1);
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_done_reg;
                    if (res_done_reg)
                        m_tdata_next = '0;
                    else
                        m_tdata_next = {4'd0, m_reg[RGB_W-1:0], 5'(h_reg), 5'(w_reg),
                                        pz, py, px, m_reg[RGB_W], axis_reg};
                end
            end
            default:
            begin
            end
        endcase

        // restart on a voxel write or a register write
        if ((in_acc && s_tuser == KIND_WRITE) || cfg_wr)
        begin
            axis_next       = '0;
            slice_next      = '0;
            row_next        = '0;
            col_next        = '0;
            mask_ready_next = 1'b0;
            all_done_next   = 1'b0;
        end
    end

    always_comb
    begin
        unique case (axis_reg)
            AXIS_X:
            begin
                px = 5'(slice_reg); py = 5'(col_reg); pz = 5'(row_reg);
            end
            AXIS_Y:
            begin
                px = 5'(row_reg); py = 5'(slice_reg); pz = 5'(col_reg);
            end
            default:
            begin
                px = 5'(col_reg); py = 5'(row_reg); pz = 5'(slice_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            axis_reg       <= '0;
            slice_reg      <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            mask_ready_reg <= 1'b0;
            all_done_reg   <= 1'b0;
            p_vld_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            axis_reg       <= axis_next;
            slice_reg      <= slice_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            mask_ready_reg <= mask_ready_next;
            all_done_reg   <= all_done_next;
            p_vld_reg      <= p_vld_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bi_reg       <= bi_next;
        bj_reg       <= bj_next;
        w_reg        <= w_next;
        h_reg        <= h_next;
        k_reg        <= k_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        m_reg        <= m_next;
        res_done_reg <= res_done_next;
        p_aok_reg    <= p_aok_next;
        p_bok_reg    <= p_bok_next;
        p_idx_reg    <= p_idx_next;
        m_tuser_reg  <= m_tuser_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_done_axis: assert property (@(posedge clk) disable iff (!rst_n)
        all_done_reg |-> axis_reg == 2'd3)
        else $error("mesher done before passing the last axis");

    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tdata == '0)
        else $error("done result carries quad fields");

    a_quad_span: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[22:18] != 5'd0 || DIM >= 32))
        else $error("quad with zero width");

    a_build_wr: assert property (@(posedge clk) disable iff (!rst_n)
        p_vld_reg |-> !$past(state_reg == ST_CLEAR))
        else $error("mask build write follows a clear cycle");
`endif

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the greedy voxel face mesher.
// Writes voxels, fetches merged quads and checks them against its own mesh walk.
// Depends on gvfm_pkg and greedy_voxel_face_mesher.
`timescale 1ns / 1ps

module testbench;
    import gvfm_pkg::*;

    typedef struct packed {
        bit        done;
        bit [1:0]  axis;
        bit        pos_face;
        bit [4:0]  px;
        bit [4:0]  py;
        bit [4:0]  pz;
        bit [4:0]  su;
        bit [4:0]  sv;
        bit [23:0] rgb;
    } quad_t;

    class quad_scoreboard;
        bit [24:0] voxels[4096];
        bit [25:0] mask[256];
        int        size[3];
        int        w_axis, w_slice, w_row, w_col;
        bit        ready, finished;
        quad_t     pending[$];
        int        errors;

        function new();
            foreach (voxels[k]) voxels[k] = '0;
            foreach (mask[k]) mask[k] = '0;
            size[0] = 16;
            size[1] = 16;
            size[2] = 16;
            errors = 0;
            restart();
        endfunction

        function void restart();
            w_axis = 0;
            w_slice = 0;
            w_row = 0;
            w_col = 0;
            ready = 0;
            finished = 0;
        endfunction

        function int ext(int a);
            return size[a] > 16 ? 16 : size[a];
        endfunction

        function void set_size(int a, int v);
            size[a] = v & 31;
            restart();
        endfunction

        function bit [24:0] vox_at(int p[3]);
            for (int k = 0; k < 3; k++)
                if (p[k] < 0 || p[k] >= ext(k))
                    return '0;
            return voxels[(p[2] * 16 + p[1]) * 16 + p[0]];
        endfunction

        function void build(int d, int s);
            int        u, v;
            int        pa[3], pb[3];
            bit [24:0] ea, eb;
            u = (d + 1) % 3;
            v = (d + 2) % 3;
            for (int j = 0; j < ext(v); j++)
                for (int i = 0; i < ext(u); i++)
                begin
                    pa[d] = s - 1;
                    pb[d] = s;
                    pa[u] = i;
                    pb[u] = i;
                    pa[v] = j;
                    pb[v] = j;
                    ea = vox_at(pa);
                    eb = vox_at(pb);
                    if (ea[24] != eb[24])
                        mask[j * 16 + i] = ea[24] ? {2'b11, ea[23:0]} : {2'b10, eb[23:0]};
                    else
                        mask[j * 16 + i] = '0;
                end
        endfunction

        // Returns whether the request is expected to answer done.
        function bit note(bit kind, bit [IN_TDATA_W-1:0] data);
            quad_t     q;
            int        d, u, v, uu, vv, w, h, i0;
            int        pos[3];
            bit        ok;
            bit [25:0] m;
            q = '0;
            if (kind == KIND_WRITE)
            begin
                voxels[(data[11:8] * 16 + data[7:4]) * 16 + data[3:0]] =
                    {data[12], data[36:13]};
                restart();
                q.done = 1;
                pending.insert(pending.size(), q);
                return 1;
            end
            while (!finished)
            begin
                d = w_axis;
                u = (d + 1) % 3;
                v = (d + 2) % 3;
                uu = ext(u);
                vv = ext(v);
                if (!ready)
                begin
                    build(d, w_slice);
                    ready = 1;
                    w_row = 0;
                    w_col = 0;
                end
                for (int j = w_row; j < vv; j++)
                begin
                    i0 = (j == w_row) ? w_col : 0;
                    for (int i = i0; i < uu; i++)
                    begin
                        m = mask[j * 16 + i];
                        if (m == 0)
                            continue;
                        w = 1;
                        h = 1;
                        while (i + w < uu && mask[j * 16 + i + w] == m)
                            w++;
                        ok = 1;
                        while (ok && j + h < vv)
                        begin
                            for (int k = 0; k < w; k++)
                                if (mask[(j + h) * 16 + i + k] != m)
                                    ok = 0;
                            if (ok)
                                h++;
                        end
                        for (int y = 0; y < h; y++)
                            for (int x = 0; x < w; x++)
                                mask[(j + y) * 16 + i + x] = '0;
                        w_row = j;
                        w_col = i;
                        pos[d] = w_slice;
                        pos[u] = i;
                        pos[v] = j;
                        q.axis = 2'(d);
                        q.pos_face = m[24];
                        q.px = 5'(pos[0]);
                        q.py = 5'(pos[1]);
                        q.pz = 5'(pos[2]);
                        q.su = 5'(w);
                        q.sv = 5'(h);
                        q.rgb = m[23:0];
                        pending.insert(pending.size(), q);
                        return 0;
                    end
                end
                ready = 0;
                w_slice++;
                if (w_slice > ext(d))
                begin
                    w_slice = 0;
                    w_axis++;
                    if (w_axis >= 3)
                        finished = 1;
                end
            end
            q.done = 1;
            pending.insert(pending.size(), q);
            return 1;
        endfunction

        function void cmp(string name, int exp_v, int act_v);
            if (exp_v != act_v)
            begin
                $error("%s: expected %0h, got %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check(bit user, bit [OUT_TDATA_W-1:0] data);
            quad_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result: done_res %0h tdata %0h", user, data);
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("done_res", e.done, user);
            cmp("axis", e.axis, data[1:0]);
            cmp("faces_positive", e.pos_face, data[2]);
            cmp("pos_x", e.px, data[7:3]);
            cmp("pos_y", e.py, data[12:8]);
            cmp("pos_z", e.pz, data[17:13]);
            cmp("span_u", e.su, data[22:18]);
            cmp("span_v", e.sv, data[27:23]);
            cmp("quad_rgb", e.rgb, data[51:28]);
        endfunction
    endclass

    logic                   clk = 0;
    logic                   rst_n = 0;
    logic                   s_tvalid = 0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 0;
    logic                   m_tvalid;
    logic                   m_tready = 0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   psel = 0;
    logic                   penable = 0;
    logic                   pwrite = 0;
    logic [3:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    quad_scoreboard sb = new();
    int send_idle = 9;
    int recv_idle = 71;
    int n_items = 0;

    greedy_voxel_face_mesher i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check(m_tuser, m_tdata);

    initial
    begin
        #200ms;
        $display("status: fail");
        $finish;
    end

    function automatic bit [IN_TDATA_W-1:0] vox(int x, int y, int z, bit solid, int rgb);
        return {3'b000, rgb[23:0], solid, z[3:0], y[3:0], x[3:0]};
    endfunction

    task automatic put(input bit kind, input bit [IN_TDATA_W-1:0] data, output bit done);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= kind;
        s_tdata <= data;
        do
            @(posedge clk);
        while (!s_tready);
        done = sb.note(kind, data);
        n_items++;
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input int value);
        drain();
        @(negedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1;
        @(posedge clk);
        sb.set_size(idx, value);
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic fetch_out(input int limit);
        bit done;
        for (int k = 0; k < limit; k++)
        begin
            put(KIND_FETCH, IN_TDATA_W'({$urandom, $urandom}), done);
            if (done)
                break;
        end
    endtask

    task automatic random_group();
        bit done;
        int e[3];
        int x, y, z, rgb;
        int palette[4] = '{32'hff0000, 32'h00ff00, 32'h0000ff, 32'hffffff};
        if ($urandom_range(2) == 0)
        begin
            for (int a = 0; a < 3; a++)
            begin
                e[a] = $urandom_range(1, 5);
                if ($urandom_range(11) == 0)
                    e[a] = ($urandom_range(2) == 0) ? 0 : ($urandom_range(1) ? 16 : 31);
                set_reg(2'(a), e[a]);
            end
        end
        for (int a = 0; a < 3; a++)
            e[a] = sb.ext(a) == 0 ? 1 : sb.ext(a);
        repeat ($urandom_range(1, 12))
        begin
            x = $urandom_range(15);
            y = $urandom_range(15);
            z = $urandom_range(15);
            if ($urandom_range(4) != 0)
            begin
                x = $urandom_range(e[0] - 1);
                y = $urandom_range(e[1] - 1);
                z = $urandom_range(e[2] - 1);
            end
            rgb = ($urandom_range(3) == 0) ? $urandom : palette[$urandom_range(3)];
            put(KIND_WRITE, vox(x, y, z, $urandom_range(6) != 0, rgb), done);
        end
        for (int k = 0; k < 40; k++)
        begin
            if ($urandom_range(19) == 0)
                put(KIND_WRITE, IN_TDATA_W'({$urandom, $urandom}), done);
            put(KIND_FETCH, IN_TDATA_W'({$urandom, $urandom}), done);
            if (done)
            begin
                if ($urandom_range(2) == 0)
                    put(KIND_FETCH, IN_TDATA_W'({$urandom, $urandom}), done);
                break;
            end
        end
    endtask

    initial
    begin
        bit done;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // full volume: corners, a merge pair, then walk to completion and beyond
        put(KIND_WRITE, vox(0, 0, 0, 1, 24'hffffff), done);
        put(KIND_WRITE, vox(1, 0, 0, 1, 24'hffffff), done);
        put(KIND_WRITE, vox(15, 15, 15, 1, 24'h000000), done);
        fetch_out(30);
        put(KIND_FETCH, '1, done);

        // zero and oversized extents
        set_reg(REG_SIZE_X, 0);
        set_reg(REG_SIZE_Y, 31);
        set_reg(REG_SIZE_Z, 1);
        put(KIND_FETCH, '0, done);
        set_reg(REG_SIZE_X, 1);
        set_reg(REG_SIZE_Y, 1);
        put(KIND_WRITE, vox(5, 5, 5, 1, 24'h123456), done);
        put(KIND_WRITE, vox(0, 0, 0, 0, 24'hffffff), done);
        fetch_out(4);
        put(KIND_WRITE, vox(0, 0, 0, 1, 24'hab00cd), done);
        fetch_out(10);
        set_reg(REG_SIZE_Z, 16);

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 9 : (ph == 1) ? 71 : 0;
            recv_idle = (ph == 0) ? 71 : (ph == 1) ? 9 : 0;
            drain();
            while (n_items < 30 + 580 * (ph + 1))
                random_group();
        end

        drain();
        repeat (2000) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
